/* rtl/sarq_pkg.sv */
// Shared types and constants for the sprite animation ring queue.
package sarq_pkg;

   localparam int SLOTS_DEF       = 10;
   localparam int ANIM_FRAMES_DEF = 8;
   localparam int HOLD_TICKS_DEF  = 4;

   localparam logic [7:0] BASE_TILE_RST    = 8'h30;
   localparam logic [7:0] PALETTE_ATTR_RST = 8'h01;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic CSR_BASE_TILE    = 1'b0;
   localparam logic CSR_PALETTE_ATTR = 1'b1;

   localparam int RECIP_SHIFT = 16;

   typedef struct packed {
      logic       opcode;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
   } req_type;

   typedef struct packed {
      logic [7:0] sprite_x;
      logic [7:0] drift_y;
      logic [7:0] tile_id;
      logic [7:0] attr;
      logic       last_sprite;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic wr_add;
      logic emit;
      logic last;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic cd_expire;
   } status_type;

endpackage

/* rtl/sarq_ctrl.sv */
// Controller: ring indexes, slot walk sequencing and input transfer control.
module sarq_ctrl #(
   parameter int SLOTS = sarq_pkg::SLOTS_DEF,
   localparam int IDX_W = $clog2(SLOTS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sarq_pkg::req_type    req_data,
   input  sarq_pkg::status_type status,
   output sarq_pkg::cmd_type    cmd,
   output logic [IDX_W-1:0]     wr_addr,
   output logic [IDX_W-1:0]     rd_addr
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic             state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0] stop_ff, stop_in;
   logic             req_accept;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
      next_idx = (i == IDX_W'(SLOTS - 1)) ? '0 : i + 1'b1;
   endfunction

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      cur_in   = cur_ff;
      stop_in  = stop_ff;
      cmd      = '0;
      wr_addr  = cur_ff;
      rd_addr  = cur_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = head_ff;
            if (req_accept) begin
               if (req_data.opcode == sarq_pkg::OP_ADD) begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_add = 1'b1;
                  wr_addr    = tail_ff;
                  tail_in    = next_idx(tail_ff);
                  if (next_idx(tail_ff) == head_ff) begin
                     head_in = next_idx(head_ff);
                  end
               end else if (head_ff != tail_ff) begin
                  cur_in   = head_ff;
                  stop_in  = tail_ff;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (status.out_free) begin
               cmd.emit  = 1'b1;
               cmd.wr_en = 1'b1;
               cmd.last  = (next_idx(cur_ff) == stop_ff);
               rd_addr   = next_idx(cur_ff);
               cur_in    = next_idx(cur_ff);
               if (status.cd_expire) begin
                  head_in = next_idx(head_ff);
               end
               if (next_idx(cur_ff) == stop_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      stop_ff <= stop_in;
   end

   a_walk_not_at_stop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (cur_ff != stop_ff))
      else $error("walk cursor reached stop index");

   a_add_not_empty: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.opcode == sarq_pkg::OP_ADD) |=> (head_ff != tail_ff))
      else $error("ring empty after add");

   a_empty_tick_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.opcode == sarq_pkg::OP_TICK && head_ff == tail_ff)
      |=> (state_ff == ST_IDLE))
      else $error("empty tick started a walk");

endmodule

/* rtl/sarq_datapath.sv */
// Datapath: slot memory, configuration registers, sprite math and output register.
module sarq_datapath #(
   parameter int SLOTS       = sarq_pkg::SLOTS_DEF,
   parameter int ANIM_FRAMES = sarq_pkg::ANIM_FRAMES_DEF,
   parameter int HOLD_TICKS  = sarq_pkg::HOLD_TICKS_DEF,
   localparam int IDX_W = $clog2(SLOTS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sarq_pkg::cmd_type    cmd,
   input  logic [IDX_W-1:0]     wr_addr,
   input  logic [IDX_W-1:0]     rd_addr,
   input  sarq_pkg::req_type    req_data,
   output sarq_pkg::status_type status,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [7:0]           csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sarq_pkg::rsp_type    rsp_data
);

   localparam int FULL_COUNT = ANIM_FRAMES * HOLD_TICKS - 1;
   localparam int CD_W       = (FULL_COUNT == 0) ? 8 : $clog2(FULL_COUNT + 1);
   localparam int RECIP      = ((1 << sarq_pkg::RECIP_SHIFT) + HOLD_TICKS - 1) / HOLD_TICKS;
   localparam int RECIP_W    = sarq_pkg::RECIP_SHIFT + 1;
   localparam int MUL_W      = 8 + RECIP_W;

   localparam logic [CD_W-1:0]    FULL_CD  = CD_W'(FULL_COUNT);
   localparam logic [7:0]         FULL8    = 8'(FULL_COUNT);
   localparam logic [7:0]         AFM1     = 8'(ANIM_FRAMES - 1);
   localparam logic [RECIP_W-1:0] RECIP_V  = RECIP_W'(RECIP);

   logic [7:0]      x_mem  [SLOTS];
   logic [7:0]      y_mem  [SLOTS];
   logic [CD_W-1:0] cd_mem [SLOTS];

   logic [7:0]       rd_x_ff;
   logic [7:0]       rd_y_ff;
   logic [CD_W-1:0]  rd_cd_ff;
   logic [7:0]       base_tile_ff, base_tile_in;
   logic [7:0]       palette_attr_ff, palette_attr_in;
   logic             rsp_valid_ff;
   sarq_pkg::rsp_type rsp_data_ff;

   logic [CD_W-1:0]  cd_dec;
   logic [7:0]       cd8;
   logic [MUL_W-1:0] product;
   logic [7:0]       quot;
   sarq_pkg::rsp_type sprite;

   assign csr_ready = 1'b1;

   always_comb begin
      base_tile_in    = base_tile_ff;
      palette_attr_in = palette_attr_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sarq_pkg::CSR_BASE_TILE:    base_tile_in    = csr_data;
            sarq_pkg::CSR_PALETTE_ATTR: palette_attr_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_tile_ff    <= sarq_pkg::BASE_TILE_RST;
         palette_attr_ff <= sarq_pkg::PALETTE_ATTR_RST;
      end else begin
         base_tile_ff    <= base_tile_in;
         palette_attr_ff <= palette_attr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         cd_mem[wr_addr] <= cmd.wr_add ? FULL_CD : cd_dec;
      end
      if (cmd.wr_en && cmd.wr_add) begin
         x_mem[wr_addr] <= req_data.pos_x;
         y_mem[wr_addr] <= req_data.pos_y;
      end
      rd_x_ff  <= x_mem[rd_addr];
      rd_y_ff  <= y_mem[rd_addr];
      rd_cd_ff <= cd_mem[rd_addr];
   end

   always_comb begin
      cd_dec  = rd_cd_ff - 1'b1;
      cd8     = 8'(rd_cd_ff);
      product = MUL_W'(cd8) * MUL_W'(RECIP_V);
      quot    = product[sarq_pkg::RECIP_SHIFT +: 8];
      sprite.sprite_x    = rd_x_ff;
      sprite.drift_y     = rd_y_ff + cd8 - FULL8;
      sprite.tile_id     = base_tile_ff + (AFM1 - quot);
      sprite.attr        = palette_attr_ff;
      sprite.last_sprite = cmd.last;
   end

   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.cd_expire = (cd_dec == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= sprite;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("sprite loaded over a pending transfer");

   a_emit_writes_back: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (cmd.wr_en && !cmd.wr_add))
      else $error("emitted sprite without countdown update");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (rsp_valid_ff && rsp_data_ff.attr == $past(palette_attr_ff)))
      else $error("loaded sprite not presented");

endmodule

/* rtl/sprite_animation_ring_queue_unit.sv */
// Top level of the sprite animation ring queue.
// An add (opcode 0) stores a new animation at the ring tail, dropping the oldest
// slot when the ring is full; at most SLOTS-1 slots are active. A tick (opcode 1)
// emits one sprite per active slot, oldest first, at one sprite per cycle while
// rsp_stall is low; the walk rate is set by the single read port of the slot memory.
// req_stall stays high during the walk. An empty tick emits nothing. The last sprite
// of a tick has last_sprite set. Configuration registers (index 0 base_tile, index 1
// palette_attr) are always ready; the user must write them only while the block is
// idle, and the block itself does not enforce this.
module sprite_animation_ring_queue_unit #(
   parameter int SLOTS       = sarq_pkg::SLOTS_DEF,
   parameter int ANIM_FRAMES = sarq_pkg::ANIM_FRAMES_DEF,
   parameter int HOLD_TICKS  = sarq_pkg::HOLD_TICKS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sarq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sarq_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [7:0]        csr_data
);

   localparam int IDX_W = $clog2(SLOTS);

   sarq_pkg::cmd_type    cmd;
   sarq_pkg::status_type status;
   logic [IDX_W-1:0]     wr_addr;
   logic [IDX_W-1:0]     rd_addr;

   sarq_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .status    (status),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr)
   );

   sarq_datapath #(
      .SLOTS       (SLOTS),
      .ANIM_FRAMES (ANIM_FRAMES),
      .HOLD_TICKS  (HOLD_TICKS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .req_data  (req_data),
      .status    (status),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* sim/tb.sv */
// Self-checking testbench for the sprite animation ring queue unit.
module tb;

   localparam int FULL_COUNT   = sarq_pkg::ANIM_FRAMES_DEF * sarq_pkg::HOLD_TICKS_DEF - 1;
   localparam int DRAIN_CYCLES = 2 * sarq_pkg::SLOTS_DEF + 4;
   localparam int IDLE_LIMIT   = 1000;

   class sprite_tracker;
      logic [7:0] base_tile;
      logic [7:0] palette_attr;
      logic [7:0] slot_x [sarq_pkg::SLOTS_DEF];
      logic [7:0] slot_y [sarq_pkg::SLOTS_DEF];
      logic [7:0] slot_cd [sarq_pkg::SLOTS_DEF];
      int         head;
      int         tail;
      sarq_pkg::rsp_type expected_sprites[$];
      int         error_count;

      function new();
         base_tile    = sarq_pkg::BASE_TILE_RST;
         palette_attr = sarq_pkg::PALETTE_ATTR_RST;
         head         = 0;
         tail         = 0;
         error_count  = 0;
      endfunction

      function int next_slot(input int i);
         return (i + 1 >= sarq_pkg::SLOTS_DEF) ? 0 : i + 1;
      endfunction

      function void set_register(input logic idx, input logic [7:0] value);
         if (idx == sarq_pkg::CSR_BASE_TILE) begin
            base_tile = value;
         end else begin
            palette_attr = value;
         end
      endfunction

      function int backlog();
         return expected_sprites.size();
      endfunction

      function void take_request(input sarq_pkg::req_type item);
         int         i;
         int         stop;
         int         n;
         logic [7:0] cd;
         sarq_pkg::rsp_type s;
         if (item.opcode == sarq_pkg::OP_ADD) begin
            slot_x[tail]  = item.pos_x;
            slot_y[tail]  = item.pos_y;
            slot_cd[tail] = 8'(FULL_COUNT);
            tail = next_slot(tail);
            if (tail == head) head = next_slot(head);
         end else begin
            i    = head;
            stop = tail;
            n    = 0;
            while (i != stop && n < sarq_pkg::SLOTS_DEF) begin
               cd            = slot_cd[i];
               s.sprite_x    = slot_x[i];
               s.drift_y     = 8'(int'(slot_y[i]) + int'(cd) - FULL_COUNT);
               s.tile_id     = 8'(int'(base_tile) + sarq_pkg::ANIM_FRAMES_DEF - 1
                                  - int'(cd) / sarq_pkg::HOLD_TICKS_DEF);
               s.attr        = palette_attr;
               s.last_sprite = (next_slot(i) == stop);
               expected_sprites.push_back(s);
               cd         = cd - 8'd1;
               slot_cd[i] = cd;
               if (cd == 8'd0) head = next_slot(head);
               i = next_slot(i);
               n++;
            end
         end
      endfunction

      function void check_field(input string name, input int exp_v, input int act_v);
         if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            error_count++;
         end
      endfunction

      function void check_sprite(input sarq_pkg::rsp_type got);
         sarq_pkg::rsp_type want;
         if (expected_sprites.size() == 0) begin
            $display("%0t: unexpected sprite, expected none actual %h", $time, got);
            error_count++;
         end else begin
            want = expected_sprites.pop_front();
            check_field("sprite_x", want.sprite_x, got.sprite_x);
            check_field("drift_y", want.drift_y, got.drift_y);
            check_field("tile_id", want.tile_id, got.tile_id);
            check_field("attr", want.attr, got.attr);
            check_field("last_sprite", want.last_sprite, got.last_sprite);
         end
      endfunction
   endclass

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   sarq_pkg::req_type req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   sarq_pkg::rsp_type rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = sarq_pkg::CSR_BASE_TILE;
   logic [7:0] csr_data  = 8'd0;

   sprite_tracker tracker = new();

   bit tx_burst = 1'b0;
   bit rx_burst = 1'b0;
   int rx_hold  = 0;
   int idle_cycles = 0;

   sprite_animation_ring_queue_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            tracker.check_sprite(rsp_data);
            rx_hold = rx_burst ? 0 : $urandom_range(0, 5);
            if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
         end else if (rx_hold > 0) begin
            rx_hold--;
         end
         rsp_stall <= (rx_hold != 0);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic sarq_pkg::req_type make_item(input logic op, input logic [7:0] x,
                                                   input logic [7:0] y);
      sarq_pkg::req_type r;
      r.opcode = op;
      r.pos_x  = x;
      r.pos_y  = y;
      return r;
   endfunction

   task automatic send_item(input sarq_pkg::req_type item);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 5);
      if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      tracker.take_request(item);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.backlog() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(input logic [7:0] tile, input logic [7:0] attr_byte);
      csr_valid <= 1'b1;
      csr_index <= sarq_pkg::CSR_BASE_TILE;
      csr_data  <= tile;
      do @(posedge clock); while (!csr_ready);
      tracker.set_register(sarq_pkg::CSR_BASE_TILE, tile);
      csr_index <= sarq_pkg::CSR_PALETTE_ATTR;
      csr_data  <= attr_byte;
      do @(posedge clock); while (!csr_ready);
      tracker.set_register(sarq_pkg::CSR_PALETTE_ATTR, attr_byte);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int count, input int add_pct);
      logic op;
      for (int k = 0; k < count; k++) begin
         op = ($urandom_range(0, 99) < add_pct) ? sarq_pkg::OP_ADD : sarq_pkg::OP_TICK;
         send_item(make_item(op, 8'($urandom), 8'($urandom)));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(make_item(sarq_pkg::OP_TICK, 8'h00, 8'h00));
      send_item(make_item(sarq_pkg::OP_ADD, 8'h00, 8'h00));
      send_item(make_item(sarq_pkg::OP_ADD, 8'hff, 8'hff));
      send_item(make_item(sarq_pkg::OP_ADD, 8'haa, 8'h55));
      send_item(make_item(sarq_pkg::OP_ADD, 8'h55, 8'haa));
      send_item(make_item(sarq_pkg::OP_TICK, 8'hff, 8'hff));
      send_item(make_item(sarq_pkg::OP_TICK, 8'h00, 8'h00));
      for (int k = 0; k < 7; k++) begin
         send_item(make_item(sarq_pkg::OP_ADD, 8'($urandom), 8'($urandom)));
      end
      send_item(make_item(sarq_pkg::OP_TICK, 8'h00, 8'h00));
      send_item(make_item(sarq_pkg::OP_ADD, 8'h80, 8'h01));
      send_item(make_item(sarq_pkg::OP_TICK, 8'h00, 8'h00));
      send_item(make_item(sarq_pkg::OP_TICK, 8'h00, 8'h00));

      settle();
      load_config(8'h00, 8'h00);
      run_random(80, 45);

      settle();
      load_config(8'hff, 8'hff);
      run_random(80, 20);

      settle();
      load_config(8'($urandom), 8'($urandom));
      run_random(80, 8);

      settle();
      load_config(8'hfc, 8'h80);
      run_random(80, 60);

      settle();
      if (tracker.error_count == 0 && tracker.backlog() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end
endmodule
